### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/pfq_pkg.sv
package pfq_pkg;

    typedef enum logic [2:0] {
        KIND_A,
        KIND_L,
        KIND_LA,
        KIND_I,
        KIND_RGB,
        KIND_RGBA
    } kind_t;

    typedef enum logic [4:0] {
        FMT_A1, FMT_A2, FMT_A4, FMT_A8,
        FMT_L1, FMT_L2, FMT_L4, FMT_L8,
        FMT_LA1, FMT_LA2, FMT_LA4, FMT_LA8,
        FMT_I1, FMT_I2, FMT_I4, FMT_I8,
        FMT_RGB232, FMT_RGB332, FMT_RGB565, FMT_RGB8,
        FMT_RGB5A1, FMT_RGBA1, FMT_RGBA2, FMT_RGBA4, FMT_RGBA6, FMT_RGBA8
    } fmt_code_t;

    localparam logic [4:0] FMT_RESET = FMT_RGBA8;
    localparam logic [4:0] FMT_COUNT = 5'd26;

    // floor(x / 3) == (x * 683) >> 11 for every x up to 3 * 255
    localparam logic [10:0] DIV3_MUL = 11'd683;
    localparam int DIV3_SHIFT = 11;

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;
    localparam int CH_A = 3;

    typedef logic [3:0] nbits_t;

    typedef struct packed {
        logic   known;
        kind_t  kind;
        nbits_t rbits;
        nbits_t gbits;
        nbits_t bbits;
        nbits_t abits;
    } fmt_desc_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pix_t;

    // one output channel before widening
    typedef struct packed {
        logic [7:0] val;
        nbits_t     nbits;
        logic       fill;   // force 0xFF
        logic       zero;   // force 0x00
    } chan_t;

    function automatic fmt_desc_t mk_desc(input kind_t kind, input nbits_t r, input nbits_t g,
                                          input nbits_t b, input nbits_t a);
        fmt_desc_t d;
        d.known = 1'b1;
        d.kind  = kind;
        d.rbits = r;
        d.gbits = g;
        d.bbits = b;
        d.abits = a;
        return d;
    endfunction

    function automatic fmt_desc_t fmt_lookup(input logic [4:0] code);
        fmt_desc_t d;
        d = '0;
        unique case (code)
            FMT_A1:     d = mk_desc(KIND_A, 4'd1, 4'd1, 4'd1, 4'd1);
            FMT_A2:     d = mk_desc(KIND_A, 4'd2, 4'd2, 4'd2, 4'd2);
            FMT_A4:     d = mk_desc(KIND_A, 4'd4, 4'd4, 4'd4, 4'd4);
            FMT_A8:     d = mk_desc(KIND_A, 4'd8, 4'd8, 4'd8, 4'd8);
            FMT_L1:     d = mk_desc(KIND_L, 4'd1, 4'd1, 4'd1, 4'd1);
            FMT_L2:     d = mk_desc(KIND_L, 4'd2, 4'd2, 4'd2, 4'd2);
            FMT_L4:     d = mk_desc(KIND_L, 4'd4, 4'd4, 4'd4, 4'd4);
            FMT_L8:     d = mk_desc(KIND_L, 4'd8, 4'd8, 4'd8, 4'd8);
            FMT_LA1:    d = mk_desc(KIND_LA, 4'd1, 4'd1, 4'd1, 4'd1);
            FMT_LA2:    d = mk_desc(KIND_LA, 4'd2, 4'd2, 4'd2, 4'd2);
            FMT_LA4:    d = mk_desc(KIND_LA, 4'd4, 4'd4, 4'd4, 4'd4);
            FMT_LA8:    d = mk_desc(KIND_LA, 4'd8, 4'd8, 4'd8, 4'd8);
            FMT_I1:     d = mk_desc(KIND_I, 4'd1, 4'd1, 4'd1, 4'd1);
            FMT_I2:     d = mk_desc(KIND_I, 4'd2, 4'd2, 4'd2, 4'd2);
            FMT_I4:     d = mk_desc(KIND_I, 4'd4, 4'd4, 4'd4, 4'd4);
            FMT_I8:     d = mk_desc(KIND_I, 4'd8, 4'd8, 4'd8, 4'd8);
            FMT_RGB232: d = mk_desc(KIND_RGB, 4'd2, 4'd3, 4'd2, 4'd8);
            FMT_RGB332: d = mk_desc(KIND_RGB, 4'd3, 4'd3, 4'd2, 4'd8);
            FMT_RGB565: d = mk_desc(KIND_RGB, 4'd5, 4'd6, 4'd5, 4'd8);
            FMT_RGB8:   d = mk_desc(KIND_RGB, 4'd8, 4'd8, 4'd8, 4'd8);
            FMT_RGB5A1: d = mk_desc(KIND_RGBA, 4'd5, 4'd5, 4'd5, 4'd1);
            FMT_RGBA1:  d = mk_desc(KIND_RGBA, 4'd1, 4'd1, 4'd1, 4'd1);
            FMT_RGBA2:  d = mk_desc(KIND_RGBA, 4'd2, 4'd2, 4'd2, 4'd2);
            FMT_RGBA4:  d = mk_desc(KIND_RGBA, 4'd4, 4'd4, 4'd4, 4'd4);
            FMT_RGBA6:  d = mk_desc(KIND_RGBA, 4'd6, 4'd6, 4'd6, 4'd6);
            FMT_RGBA8:  d = mk_desc(KIND_RGBA, 4'd8, 4'd8, 4'd8, 4'd8);
            default:    d = '0;
        endcase
        return d;
    endfunction

    // keep the top n bits and repeat them down the byte
    function automatic logic [7:0] widen(input logic [7:0] v, input nbits_t n);
        logic [7:0] res;
        case (n)
            4'd1:    res = {8{v[7]}};
            4'd2:    res = {4{v[7:6]}};
            4'd3:    res = {v[7:5], v[7:5], v[7:6]};
            4'd4:    res = {2{v[7:4]}};
            4'd5:    res = {v[7:3], v[7:5]};
            4'd6:    res = {v[7:2], v[7:6]};
            4'd7:    res = {v[7:1], v[7]};
            default: res = v;
        endcase
        return res;
    endfunction

endpackage

### rtl/pfq_decode.sv
module pfq_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             ready,
    input  logic             down_ready,
    input  logic [4:0]       pixel_format,
    input  pfq_pkg::pix_t    pix_in,
    output logic             valid,
    output pfq_pkg::fmt_desc_t desc,
    output pfq_pkg::pix_t    pix,
    output logic [9:0]       sum3,
    output logic [9:0]       sum4
);
    import pfq_pkg::*;

    logic       valid_reg;
    fmt_desc_t  desc_reg;
    pix_t       pix_reg;
    logic [9:0] sum3_reg;
    logic [9:0] sum4_reg;
    logic [9:0] sum3_next;

    assign ready = !valid_reg || down_ready;
    assign sum3_next = {2'b00, pix_in.red} + {2'b00, pix_in.green} + {2'b00, pix_in.blue};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            desc_reg <= fmt_lookup(pixel_format);
            pix_reg  <= pix_in;
            sum3_reg <= sum3_next;
            sum4_reg <= sum3_next + {2'b00, pix_in.alpha};
        end
    end

    assign valid = valid_reg;
    assign desc  = desc_reg;
    assign pix   = pix_reg;
    assign sum3  = sum3_reg;
    assign sum4  = sum4_reg;
endmodule

### rtl/pfq_reduce.sv
module pfq_reduce (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 ready,
    input  logic                 down_ready,
    input  pfq_pkg::fmt_desc_t   desc,
    input  pfq_pkg::pix_t        pix,
    input  logic [9:0]           sum3,
    input  logic [9:0]           sum4,
    output logic                 valid,
    output pfq_pkg::chan_t [3:0] chans
);
    import pfq_pkg::*;

    logic          valid_reg;
    chan_t [3:0]   chans_reg;
    chan_t [3:0]   chans_next;
    logic [20:0]   prod;
    logic [7:0]    lum;
    logic [7:0]    ival;

    assign ready = !valid_reg || down_ready;

    // luminance by reciprocal multiply, intensity by shift
    assign prod = 21'(sum3) * 21'(DIV3_MUL);
    assign lum  = prod[DIV3_SHIFT +: 8];
    assign ival = sum4[9:2];

    function automatic chan_t mk_chan(input logic [7:0] v, input nbits_t n);
        chan_t c;
        c.val   = v;
        c.nbits = n;
        c.fill  = 1'b0;
        c.zero  = 1'b0;
        return c;
    endfunction

    function automatic chan_t fill_chan();
        chan_t c;
        c = '0;
        c.fill = 1'b1;
        return c;
    endfunction

    always_comb
    begin
        chans_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            chans_next[i].zero = 1'b1;
        end
        if (desc.known)
        begin
            case (desc.kind)
                KIND_A:
                begin
                    chans_next[CH_R] = fill_chan();
                    chans_next[CH_G] = fill_chan();
                    chans_next[CH_B] = fill_chan();
                    chans_next[CH_A] = mk_chan(pix.alpha, desc.abits);
                end
                KIND_L, KIND_LA:
                begin
                    chans_next[CH_R] = mk_chan(lum, desc.rbits);
                    chans_next[CH_G] = mk_chan(lum, desc.rbits);
                    chans_next[CH_B] = mk_chan(lum, desc.rbits);
                    chans_next[CH_A] = (desc.kind == KIND_LA) ?
                                       mk_chan(pix.alpha, desc.abits) : fill_chan();
                end
                KIND_I:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        chans_next[i] = mk_chan(ival, desc.rbits);
                    end
                end
                default:
                begin
                    chans_next[CH_R] = mk_chan(pix.red, desc.rbits);
                    chans_next[CH_G] = mk_chan(pix.green, desc.gbits);
                    chans_next[CH_B] = mk_chan(pix.blue, desc.bbits);
                    chans_next[CH_A] = (desc.kind == KIND_RGBA) ?
                                       mk_chan(pix.alpha, desc.abits) : fill_chan();
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            chans_reg <= chans_next;
        end
    end

    assign valid = valid_reg;
    assign chans = chans_reg;
endmodule

### rtl/pfq_widen.sv
module pfq_widen (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 ready,
    input  logic                 stall,
    input  pfq_pkg::chan_t [3:0] chans,
    output logic                 valid,
    output pfq_pkg::pix_t        pix
);
    import pfq_pkg::*;

    logic       valid_reg;
    pix_t       pix_reg;
    logic [7:0] val_next [4];

    assign ready = !valid_reg || !stall;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (chans[i].zero)
            begin
                val_next[i] = 8'h00;
            end
            else if (chans[i].fill)
            begin
                val_next[i] = 8'hFF;
            end
            else
            begin
                val_next[i] = widen(chans[i].val, chans[i].nbits);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            pix_reg.red   <= val_next[CH_R];
            pix_reg.green <= val_next[CH_G];
            pix_reg.blue  <= val_next[CH_B];
            pix_reg.alpha <= val_next[CH_A];
        end
    end

    assign valid = valid_reg;
    assign pix   = pix_reg;
endmodule

### rtl/pixel_format_quantizer.sv
// Pixel format quantizer: one RGBA8 pixel word in, the same pixel reduced to
// the configured format and bit-replicated back to 8 bits per channel out.
// Input channel: in_valid / in_stall with in_red, in_green, in_blue, in_alpha.
//   A word is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_red .. out_alpha, taken at an
//   edge with out_valid high and out_stall low. out_valid is a register output.
// Config channel: cfg_valid / cfg_ready / cfg_data sets pixel_format (0..25;
//   codes 26..31 give an all-zero pixel). cfg_ready is always high. Write it
//   only while the pipeline is empty; the format is sampled at stage 1 entry.
// Pipeline: an accepted word passes three registered stages (decode+sums,
//   mean+select, widen into the output register) to out_valid. Throughput:
//   one word per cycle while out_stall is low, with a single 10x11 multiply in stage 2.
// Stall: each stage holds while the stage after it is full and held, so
//   out_stall backs up through in_stall; nothing is dropped or repeated.
// Reset: rst_n clears all stage valid bits and sets the format to RGBA8.
module pixel_format_quantizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_alpha,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);
    import pfq_pkg::*;

    logic        cfg_write;
    logic [4:0]  fmt_reg;

    // stage handshakes
    logic        s1_ready;
    logic        s1_valid;
    logic        s2_ready;
    logic        s2_valid;
    logic        s3_ready;

    pix_t        pix_in;
    fmt_desc_t   s1_desc;
    pix_t        s1_pix;
    logic [9:0]  s1_sum3;
    logic [9:0]  s1_sum4;
    chan_t [3:0] s2_chans;
    pix_t        s3_pix;

    // single config register, writes always accepted
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_RESET;
        end
        else if (cfg_write)
        begin
            fmt_reg <= cfg_data;
        end
    end

    assign pix_in.red   = in_red;
    assign pix_in.green = in_green;
    assign pix_in.blue  = in_blue;
    assign pix_in.alpha = in_alpha;

    assign in_stall = !s1_ready;

    // stage 1: format decode, channel sums
    pfq_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (in_valid),
        .ready        (s1_ready),
        .down_ready   (s2_ready),
        .pixel_format (fmt_reg),
        .pix_in       (pix_in),
        .valid        (s1_valid),
        .desc         (s1_desc),
        .pix          (s1_pix),
        .sum3         (s1_sum3),
        .sum4         (s1_sum4)
    );

    // stage 2: luminance / intensity means, per-channel source select
    pfq_reduce u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .ready      (s2_ready),
        .down_ready (s3_ready),
        .desc       (s1_desc),
        .pix        (s1_pix),
        .sum3       (s1_sum3),
        .sum4       (s1_sum4),
        .valid      (s2_valid),
        .chans      (s2_chans)
    );

    // stage 3: bit replication into the output register
    pfq_widen u_widen (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .ready    (s3_ready),
        .stall    (out_stall),
        .chans    (s2_chans),
        .valid    (out_valid),
        .pix      (s3_pix)
    );

    assign out_red   = s3_pix.red;
    assign out_green = s3_pix.green;
    assign out_blue  = s3_pix.blue;
    assign out_alpha = s3_pix.alpha;
endmodule

### rtl/pfq_checker.sv
`include "assert_macros.svh"

module pfq_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_red,
    input  logic [7:0] out_green,
    input  logic [7:0] out_blue,
    input  logic [7:0] out_alpha,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [4:0] cfg_data
);
    import pfq_pkg::*;

    logic [4:0] fmt_reg;

    // shadow of the format register as seen on the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fmt_reg <= cfg_data;
        end
    end

    // input backs up only when the output is full and held
    `ASSERT_IMPLY(a_stall_backup, clk, rst_n, in_stall, out_valid && out_stall)

    // a held output word stays valid, with red and alpha unchanged
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(out_red) && $stable(out_alpha))

    // an accepted word reaches out_valid through all stages when the receiver keeps taking
    `ASSERT_NEXT(a_latency, clk, rst_n,
                 (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall, out_valid)

    // unused format codes give a black, transparent pixel
    `ASSERT_IMPLY(a_unused_zero, clk, rst_n, out_valid && (fmt_reg >= FMT_COUNT),
                  out_red == 8'h00 && out_green == 8'h00 && out_blue == 8'h00 &&
                  out_alpha == 8'h00)
endmodule

bind pixel_format_quantizer pfq_checker u_pfq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

### dv/pixel_format_quantizer_tb.sv
module pixel_format_quantizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfq_pkg::*;

    // run shape
    localparam int         PHASE_WORDS  = 46;     // random words per format setting
    localparam int         CODE_SPACE   = 32;     // every 5-bit format code, unused ones too
    localparam int         CHOKE_AT     = 250;    // accepted words before the long sink hold
    localparam int         CHOKE_CYCLES = 40;     // length of that hold, enough to back up
    localparam int         DRAIN_CYCLES = 8;      // quiet cycles after the drain, to catch stray words
    localparam int         REPORT_MAX   = 10;
    localparam logic [4:0] CODE_UNUSED_TOP = 5'd31;

    // per-format channel widths as the predictor sees them
    typedef struct {
        bit    known;
        kind_t kind;
        int    rbits;
        int    gbits;
        int    bbits;
        int    abits;
    } fmt_shape_t;

    // Expected-pixel store plus the predictor. Expectations are queued at input
    // accept, using the format held at that time (format only changes when idle).
    class quantizer_scoreboard;
        logic [4:0] format_code;
        pix_t       expected_q[$];
        int         checked;
        int         mismatches;
        int         orphans;
        int         reports;

        function new();
            format_code = FMT_RESET;
            checked     = 0;
            mismatches  = 0;
            orphans     = 0;
            reports     = 0;
        endfunction

        function fmt_shape_t shape_of(logic [4:0] code);
            fmt_shape_t s;
            s = '{1'b0, KIND_A, 8, 8, 8, 8};
            case (code)
                FMT_A1:     s = '{1'b1, KIND_A,    1, 1, 1, 1};
                FMT_A2:     s = '{1'b1, KIND_A,    2, 2, 2, 2};
                FMT_A4:     s = '{1'b1, KIND_A,    4, 4, 4, 4};
                FMT_A8:     s = '{1'b1, KIND_A,    8, 8, 8, 8};
                FMT_L1:     s = '{1'b1, KIND_L,    1, 1, 1, 1};
                FMT_L2:     s = '{1'b1, KIND_L,    2, 2, 2, 2};
                FMT_L4:     s = '{1'b1, KIND_L,    4, 4, 4, 4};
                FMT_L8:     s = '{1'b1, KIND_L,    8, 8, 8, 8};
                FMT_LA1:    s = '{1'b1, KIND_LA,   1, 1, 1, 1};
                FMT_LA2:    s = '{1'b1, KIND_LA,   2, 2, 2, 2};
                FMT_LA4:    s = '{1'b1, KIND_LA,   4, 4, 4, 4};
                FMT_LA8:    s = '{1'b1, KIND_LA,   8, 8, 8, 8};
                FMT_I1:     s = '{1'b1, KIND_I,    1, 1, 1, 1};
                FMT_I2:     s = '{1'b1, KIND_I,    2, 2, 2, 2};
                FMT_I4:     s = '{1'b1, KIND_I,    4, 4, 4, 4};
                FMT_I8:     s = '{1'b1, KIND_I,    8, 8, 8, 8};
                FMT_RGB232: s = '{1'b1, KIND_RGB,  2, 3, 2, 8};
                FMT_RGB332: s = '{1'b1, KIND_RGB,  3, 3, 2, 8};
                FMT_RGB565: s = '{1'b1, KIND_RGB,  5, 6, 5, 8};
                FMT_RGB8:   s = '{1'b1, KIND_RGB,  8, 8, 8, 8};
                FMT_RGB5A1: s = '{1'b1, KIND_RGBA, 5, 5, 5, 1};
                FMT_RGBA1:  s = '{1'b1, KIND_RGBA, 1, 1, 1, 1};
                FMT_RGBA2:  s = '{1'b1, KIND_RGBA, 2, 2, 2, 2};
                FMT_RGBA4:  s = '{1'b1, KIND_RGBA, 4, 4, 4, 4};
                FMT_RGBA6:  s = '{1'b1, KIND_RGBA, 6, 6, 6, 6};
                FMT_RGBA8:  s = '{1'b1, KIND_RGBA, 8, 8, 8, 8};
                default:    s.known = 1'b0;
            endcase
            return s;
        endfunction

        // top n bits of v, repeated down the byte
        function logic [7:0] replicate_top(logic [7:0] v, int n);
            logic [7:0] kept;
            logic [7:0] res;
            int         sh;
            kept = v & (8'hFF << (8 - n));
            res  = '0;
            for (sh = 0; sh < 8; sh += n)
                res |= kept >> sh;
            return res;
        endfunction

        function pix_t quantize(pix_t px);
            fmt_shape_t s;
            pix_t       q;
            int         mean;
            logic [7:0] lvl;
            s = shape_of(format_code);
            q = '0;
            if (s.known)
            begin
                case (s.kind)
                    KIND_A:
                    begin
                        q.red   = 8'hFF;
                        q.green = 8'hFF;
                        q.blue  = 8'hFF;
                        q.alpha = replicate_top(px.alpha, s.abits);
                    end
                    KIND_L, KIND_LA:
                    begin
                        mean    = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
                        lvl     = replicate_top(mean[7:0], s.rbits);
                        q.red   = lvl;
                        q.green = lvl;
                        q.blue  = lvl;
                        q.alpha = (s.kind == KIND_LA) ? replicate_top(px.alpha, s.abits)
                                                      : 8'hFF;
                    end
                    KIND_I:
                    begin
                        mean = (int'(px.red) + int'(px.green) + int'(px.blue)
                                + int'(px.alpha)) / 4;
                        lvl  = replicate_top(mean[7:0], s.rbits);
                        q    = '{lvl, lvl, lvl, lvl};
                    end
                    default:
                    begin
                        q.red   = replicate_top(px.red, s.rbits);
                        q.green = replicate_top(px.green, s.gbits);
                        q.blue  = replicate_top(px.blue, s.bbits);
                        q.alpha = (s.kind == KIND_RGBA) ? replicate_top(px.alpha, s.abits)
                                                        : 8'hFF;
                    end
                endcase
            end
            return q;
        endfunction

        function void note_word(pix_t px);
            expected_q.push_back(quantize(px));
        endfunction

        function void check_word(pix_t got);
            pix_t want;
            if (expected_q.size() == 0)
            begin
                orphans++;
                if (reports < REPORT_MAX)
                    $display("[%0t] unexpected output word %h (nothing pending)", $realtime, got);
                reports++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha)
            begin
                mismatches++;
                if (reports < REPORT_MAX)
                    $display("[%0t] fmt %0d: exp r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                             $realtime, format_code, want.red, want.green, want.blue,
                             want.alpha, got.red, got.green, got.blue, got.alpha);
                reports++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    bit steady;   // phase with no idling on either side
    bit choke;    // long sink hold in progress
    int pixels_in;
    int pixels_out;
    int formats_seen;

    quantizer_scoreboard sb;

    pixel_format_quantizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Channel value biased toward the corners: 0, FF, and the 80/7F edge where
    // every replication width flips its top bit.
    function automatic logic [7:0] pick_level();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = 8'h80;
            3:       v = 8'h7F;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    // Offer one pixel word after a random gap (none while steady) and hold it until taken.
    // Called just after clk rises; in_valid stays high between words sent with no gap.
    task automatic send_word(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_red   <= r;
        in_green <= g;
        in_blue  <= b;
        in_alpha <= a;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(pix_t'{r, g, b, a});
        pixels_in++;
    endtask

    // Format change: stop offering, let every pending word come out, then write.
    task automatic set_format(input logic [4:0] code);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.format_code = code;
        formats_seen++;
    endtask

    // Sink: check every accepted word, then stall for a random hold (none while steady) before
    // the next one. The long hold overrides the per-word draw.
    initial
    begin : sink
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_word(pix_t'{out_red, out_green, out_blue, out_alpha});
                pixels_out++;
                hold = steady ? 0 : $urandom_range(0, 3);
            end
            out_stall <= choke || (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    // One long hold on the output mid-phase while the source keeps offering,
    // so the pipeline fills and in_stall has to rise.
    initial
    begin : backpressure
        choke <= 1'b0;
        wait (pixels_in == CHOKE_AT);
        @(posedge clk);
        choke <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choke <= 1'b0;
    end

    // hard stop if the handshakes hang
    initial
    begin : watchdog
        #2_000_000;
        $display("pixel_format_quantizer verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [4:0] order [CODE_SPACE];
        logic [4:0] swap;
        int         i;
        int         j;
        int         k;
        int         leftover;
        int         fails;

        sb           = new();
        pixels_in    = 0;
        pixels_out   = 0;
        formats_seen = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_red    <= '0;
        in_green  <= '0;
        in_blue   <= '0;
        in_alpha  <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        steady    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset format (RGBA8) must pass every channel straight through.
        send_word(8'h00, 8'h00, 8'h00, 8'h00);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(8'h80, 8'h7F, 8'h01, 8'hFE);
        send_word(8'h55, 8'hAA, 8'h0F, 8'hF0);
        send_word(8'hFF, 8'h00, 8'h00, 8'h00);
        send_word(8'h00, 8'h00, 8'h00, 8'hFF);

        // luminance mean at its top and just under it, and a sum that truncates to 0
        set_format(FMT_L8);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_word(8'hFF, 8'hFF, 8'hFE, 8'h12);
        send_word(8'h01, 8'h01, 8'h00, 8'hFF);

        // intensity mean, same corners with alpha in the sum
        set_format(FMT_I8);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFC);
        send_word(8'h03, 8'h00, 8'h00, 8'h00);

        // one-bit alpha on both sides of the threshold
        set_format(FMT_A1);
        send_word(8'h00, 8'h00, 8'h00, 8'h80);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'h7F);

        // code with no format behind it: all-zero pixel
        set_format(CODE_UNUSED_TOP);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(8'h80, 8'h80, 8'h80, 8'h80);

        // Random: every 5-bit code once, in shuffled order, one phase each.
        for (i = 0; i < CODE_SPACE; i++)
            order[i] = i[4:0];
        for (i = CODE_SPACE - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (i = 0; i < CODE_SPACE; i++)
        begin
            set_format(order[i]);
            steady <= ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_WORDS; k++)
                send_word(pick_level(), pick_level(), pick_level(), pick_level());
        end

        // drain, then DRAIN_CYCLES quiet cycles to catch stray output words
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        leftover = sb.expected_q.size();
        fails    = sb.mismatches + sb.orphans + leftover;
        $display("Run: %0d pixel words in, %0d out, %0d format writes (all 32 codes).",
                 pixels_in, pixels_out, formats_seen);
        $display("Compared %0d: %0d wrong, %0d unexpected, %0d missing.",
                 sb.checked, sb.mismatches, sb.orphans, leftover);
        if (fails == 0)
            $display("pixel_format_quantizer verification clean");
        else
            $display("pixel_format_quantizer verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/pfq_pkg.sv
rtl/pfq_decode.sv
rtl/pfq_reduce.sv
rtl/pfq_widen.sv
rtl/pixel_format_quantizer.sv
rtl/pfq_checker.sv
dv/pixel_format_quantizer_tb.sv
